### rtl/ets_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types, token kinds, error codes and result builders for the scanner.
// ----------------------------------------------------------------------------
package ets_pkg;

  localparam int unsigned MaxLine     = 4096;
  localparam int unsigned MaxIdentLen = 15;
  localparam int unsigned PosW        = 12;
  localparam int unsigned LenW        = 13;

  typedef logic [5:0]      kind_t;
  typedef logic [3:0]      err_t;
  typedef logic [PosW-1:0] pos_t;

  localparam kind_t KIND_LPAREN = 6'd0;
  localparam kind_t KIND_RPAREN = 6'd1;
  localparam kind_t KIND_BAR    = 6'd2;
  localparam kind_t KIND_PCT    = 6'd3;
  localparam kind_t KIND_POW    = 6'd4;
  localparam kind_t KIND_STAR   = 6'd5;
  localparam kind_t KIND_PLUS   = 6'd6;
  localparam kind_t KIND_NE     = 6'd7;
  localparam kind_t KIND_BANG   = 6'd8;
  localparam kind_t KIND_COMMA  = 6'd9;
  localparam kind_t KIND_SEMI   = 6'd10;
  localparam kind_t KIND_UNDER  = 6'd11;
  localparam kind_t KIND_ARROW  = 6'd12;
  localparam kind_t KIND_MINUS  = 6'd13;
  localparam kind_t KIND_IDIV   = 6'd14;
  localparam kind_t KIND_SLASH  = 6'd15;
  localparam kind_t KIND_EQ     = 6'd16;
  localparam kind_t KIND_ASSIGN = 6'd17;
  localparam kind_t KIND_GE     = 6'd18;
  localparam kind_t KIND_GT     = 6'd19;
  localparam kind_t KIND_LE     = 6'd20;
  localparam kind_t KIND_LT     = 6'd21;
  localparam kind_t KIND_AT     = 6'd22;
  localparam kind_t KIND_DOLLAR = 6'd23;
  localparam kind_t KIND_EOL    = 6'd24;
  localparam kind_t KIND_IDENT  = 6'd25;
  localparam kind_t KIND_NUMBER = 6'd26;
  localparam kind_t KIND_AND    = 6'd27;
  localparam kind_t KIND_OR     = 6'd28;
  localparam kind_t KIND_NOT    = 6'd29;
  localparam kind_t KIND_IF     = 6'd30;
  localparam kind_t KIND_ELSE   = 6'd31;
  localparam kind_t KIND_DEF    = 6'd32;
  localparam kind_t KIND_ANS    = 6'd33;
  localparam kind_t KIND_OF     = 6'd34;
  localparam kind_t KIND_TRUE   = 6'd35;
  localparam kind_t KIND_FALSE  = 6'd36;
  localparam kind_t KIND_LET    = 6'd37;
  localparam kind_t KIND_ALIAS  = 6'd38;

  localparam err_t ERR_NONE      = 4'd0;
  localparam err_t ERR_TAB       = 4'd1;
  localparam err_t ERR_BAD_CHAR  = 4'd2;
  localparam err_t ERR_LONG_ID   = 4'd3;
  localparam err_t ERR_TWO_PT    = 4'd4;
  localparam err_t ERR_PT_IN_EXP = 4'd5;
  localparam err_t ERR_TWO_EXP   = 4'd6;
  localparam err_t ERR_TRAIL_PT  = 4'd7;
  localparam err_t ERR_EMPTY_EXP = 4'd8;
  localparam err_t ERR_LONG_LINE = 4'd9;

  typedef struct packed {
    kind_t           kind;
    pos_t            start;
    logic [LenW-1:0] len;
    err_t            err;
    pos_t            epos;
    logic            last;
  } tok_t;

  function automatic tok_t mk_tok(kind_t k, pos_t s, logic [LenW-1:0] l, logic last);
    tok_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.err   = ERR_NONE;
    t.epos  = '0;
    t.last  = last;
    return t;
  endfunction

  function automatic tok_t mk_err(err_t e, pos_t p);
    tok_t t;
    t.kind  = KIND_LPAREN;
    t.start = '0;
    t.len   = '0;
    t.err   = e;
    t.epos  = p;
    t.last  = 1'b1;
    return t;
  endfunction

endpackage

### rtl/ets_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_if
// Character and token channel interfaces.
// ----------------------------------------------------------------------------
interface ets_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  modport source (output valid, char_byte, input ready);
  modport sink (input valid, char_byte, output ready);
endinterface

interface ets_tok_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [11:0] token_start;
  logic [12:0] token_length;
  logic [3:0]  error_code;
  logic [11:0] error_position;
  logic        last_of_line;
  modport source (output valid, token_kind, token_start, token_length, error_code,
                  error_position, last_of_line, input ready);
  modport sink (input valid, token_kind, token_start, token_length, error_code,
                error_position, last_of_line, output ready);
endinterface

### rtl/ets_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_scan
// Front end: classifies one character per cycle while acc_i is high, produces up to two results.
// ----------------------------------------------------------------------------
module ets_scan import ets_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [7:0] c_i,
  output logic       push0_o,
  output logic       push1_o,
  output tok_t       res0_o,
  output tok_t       res1_o
);

  typedef enum logic [3:0] {
    M_IDLE, M_OP2, M_WORD, M_DOT, M_NUM, M_NUM_PT, M_NUM_E, M_NUM_SIGN, M_NUM_SEXP
  } mode_e;

  localparam logic [2:0] F_POINT = 3'd1;
  localparam logic [2:0] F_EXP   = 3'd2;
  localparam logic [2:0] F_SIGN  = 3'd4;

  mode_e      mode_q, mode_d;
  pos_t       pos_q, pos_d, beg_q, beg_d;
  logic [7:0] pend_q, pend_d;
  logic [4:0] wlen_q, wlen_d;
  logic [2:0] flg_q, flg_d;
  logic       skip_q, skip_d;
  logic [7:0] wch_q [5];
  logic       wc_we;
  logic [2:0] wc_idx;

  logic a_v, b_v;
  tok_t a_t, b_t;

  function automatic logic is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_let(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic kind_t word_kind(logic [4:0] n, logic [7:0] w0, logic [7:0] w1,
                                      logic [7:0] w2, logic [7:0] w3, logic [7:0] w4);
    kind_t k;
    k = KIND_IDENT;
    unique case (n)
      5'd2: begin
        if      (w0 == "o" && w1 == "r") k = KIND_OR;
        else if (w0 == "i" && w1 == "f") k = KIND_IF;
        else if (w0 == "o" && w1 == "f") k = KIND_OF;
        else if (w0 == "i" && w1 == "s") k = KIND_EQ;
        else if (w0 == "b" && w1 == "e") k = KIND_ASSIGN;
        else if (w0 == "a" && w1 == "s") k = KIND_ARROW;
      end
      5'd3: begin
        if      (w0 == "a" && w1 == "n" && w2 == "d") k = KIND_AND;
        else if (w0 == "n" && w1 == "o" && w2 == "t") k = KIND_NOT;
        else if (w0 == "d" && w1 == "e" && w2 == "f") k = KIND_DEF;
        else if (w0 == "a" && w1 == "n" && w2 == "s") k = KIND_ANS;
        else if (w0 == "l" && w1 == "e" && w2 == "t") k = KIND_LET;
      end
      5'd4: begin
        if      (w0 == "e" && w1 == "l" && w2 == "s" && w3 == "e") k = KIND_ELSE;
        else if (w0 == "t" && w1 == "r" && w2 == "u" && w3 == "e") k = KIND_TRUE;
      end
      5'd5: begin
        if (w0 == "f" && w1 == "a" && w2 == "l" && w3 == "s" && w4 == "e") k = KIND_FALSE;
        else if (w0 == "a" && w1 == "l" && w2 == "i" && w3 == "a" && w4 == "s")
          k = KIND_ALIAS;
      end
      default: k = KIND_IDENT;
    endcase
    return k;
  endfunction

  always_comb begin
    logic       rescan, failed;
    logic [4:0] wn;
    kind_t      one, pair, sk;
    logic       pair_v, sk_v;
    err_t       fe;
    pos_t       fp;
    logic [LenW-1:0] span;

    mode_d = mode_q; pos_d = pos_q; beg_d = beg_q; pend_d = pend_q;
    wlen_d = wlen_q; flg_d = flg_q; skip_d = skip_q;
    wc_we = 1'b0; wc_idx = wlen_q[2:0];
    a_v = 1'b0; b_v = 1'b0; a_t = mk_err(ERR_NONE, '0); b_t = a_t;
    rescan = 1'b0; failed = 1'b0; fe = ERR_NONE; fp = pos_q;
    one = KIND_LT; pair = KIND_LE; pair_v = 1'b0; sk = KIND_LPAREN; sk_v = 1'b0;
    wn = wlen_q + 5'd1;
    span = {1'b0, pos_q - beg_q};

    if (skip_q) begin
      if (c_i == 8'd0) begin
        pos_d = '0; mode_d = M_IDLE; beg_d = '0; pend_d = '0;
        wlen_d = '0; flg_d = '0; skip_d = 1'b0;
      end
    end else if (c_i != 8'd0 && pos_q == pos_t'(MaxLine - 1)) begin
      failed = 1'b1; fe = ERR_LONG_LINE; fp = pos_q;
    end else begin
      unique case (mode_q)
        M_OP2: begin
          unique case (pend_q)
            "*":     begin one = KIND_STAR;   pair = KIND_POW;   pair_v = c_i == "*"; end
            "!":     begin one = KIND_BANG;   pair = KIND_NE;    pair_v = c_i == "="; end
            "-":     begin one = KIND_MINUS;  pair = KIND_ARROW; pair_v = c_i == ">"; end
            "/":     begin one = KIND_SLASH;  pair = KIND_IDIV;  pair_v = c_i == "/"; end
            "=":     begin one = KIND_ASSIGN; pair = KIND_EQ;    pair_v = c_i == "="; end
            ">":     begin one = KIND_GT;     pair = KIND_GE;    pair_v = c_i == "="; end
            default: begin one = KIND_LT;     pair = KIND_LE;    pair_v = c_i == "="; end
          endcase
          mode_d = M_IDLE;
          a_v = 1'b1;
          if (pair_v) begin
            a_t = mk_tok(pair, beg_q, LenW'(2), 1'b0);
            pos_d = pos_q + 1'b1;
          end else begin
            a_t = mk_tok(one, beg_q, LenW'(1), 1'b0);
            rescan = 1'b1;
          end
        end
        M_WORD: begin
          if (is_let(c_i) || is_dig(c_i) || c_i == "_") begin
            wc_we = wlen_q < 5'd5;
            wlen_d = wn;
            if (wn > 5'(MaxIdentLen)) begin
              failed = 1'b1; fe = ERR_LONG_ID; fp = beg_q;
            end else pos_d = pos_q + 1'b1;
          end else begin
            a_v = 1'b1;
            a_t = mk_tok(word_kind(wlen_q, wch_q[0], wch_q[1], wch_q[2], wch_q[3], wch_q[4]),
                         beg_q, span, 1'b0);
            mode_d = M_IDLE; rescan = 1'b1;
          end
        end
        M_DOT: begin
          if (is_dig(c_i)) begin
            mode_d = M_NUM; flg_d = '0; pos_d = pos_q + 1'b1;
          end else begin
            failed = 1'b1; fe = ERR_BAD_CHAR; fp = pos_q - 1'b1;
          end
        end
        M_NUM, M_NUM_PT, M_NUM_E: begin
          if (is_dig(c_i)) begin
            mode_d = M_NUM; pos_d = pos_q + 1'b1;
          end else if (c_i == ".") begin
            if ((flg_q & F_POINT) != 3'd0) begin
              failed = 1'b1; fe = ERR_TWO_PT; fp = pos_q;
            end else if ((flg_q & F_EXP) != 3'd0) begin
              failed = 1'b1; fe = ERR_PT_IN_EXP; fp = pos_q;
            end else begin
              flg_d = flg_q | F_POINT; mode_d = M_NUM_PT; pos_d = pos_q + 1'b1;
            end
          end else if (c_i == "e" || c_i == "E") begin
            if ((flg_q & F_EXP) != 3'd0) begin
              failed = 1'b1; fe = ERR_TWO_EXP; fp = pos_q;
            end else begin
              flg_d = flg_q | F_EXP; mode_d = M_NUM_E; pos_d = pos_q + 1'b1;
            end
          end else if (mode_q == M_NUM_PT) begin
            failed = 1'b1; fe = ERR_TRAIL_PT; fp = pos_q - 1'b1;
          end else if (mode_q == M_NUM_E) begin
            if (c_i == "+" || c_i == "-") begin
              flg_d = flg_q | F_SIGN; mode_d = M_NUM_SIGN; pos_d = pos_q + 1'b1;
            end else begin
              failed = 1'b1; fe = ERR_EMPTY_EXP; fp = pos_q - 1'b1;
            end
          end else begin
            a_v = 1'b1; a_t = mk_tok(KIND_NUMBER, beg_q, span, 1'b0);
            mode_d = M_IDLE; rescan = 1'b1;
          end
        end
        M_NUM_SIGN: begin
          if (is_dig(c_i)) begin
            mode_d = M_NUM_SEXP; pos_d = pos_q + 1'b1;
          end else begin
            failed = 1'b1; fe = ERR_EMPTY_EXP; fp = pos_q - 2'd2;
          end
        end
        M_NUM_SEXP: begin
          if (is_dig(c_i)) pos_d = pos_q + 1'b1;
          else begin
            a_v = 1'b1; a_t = mk_tok(KIND_NUMBER, beg_q, span, 1'b0);
            mode_d = M_IDLE; rescan = 1'b1;
          end
        end
        default: begin
          mode_d = M_IDLE; rescan = 1'b1;
        end
      endcase

      if (rescan) begin
        sk_v = 1'b1;
        unique case (c_i)
          "(": sk = KIND_LPAREN;
          ")": sk = KIND_RPAREN;
          "|": sk = KIND_BAR;
          "%": sk = KIND_PCT;
          "^": sk = KIND_POW;
          "+": sk = KIND_PLUS;
          ",": sk = KIND_COMMA;
          ";": sk = KIND_SEMI;
          "_": sk = KIND_UNDER;
          "@": sk = KIND_AT;
          "$": sk = KIND_DOLLAR;
          default: sk_v = 1'b0;
        endcase
        pos_d = pos_q + 1'b1;
        if (c_i == 8'd0) begin
          b_v = 1'b1; b_t = mk_tok(KIND_EOL, pos_q, '0, 1'b1);
          pos_d = '0; mode_d = M_IDLE; beg_d = '0; pend_d = '0;
          wlen_d = '0; flg_d = '0; skip_d = 1'b0;
        end else if (sk_v) begin
          b_v = 1'b1; b_t = mk_tok(sk, pos_q, LenW'(1), 1'b0);
        end else if (c_i == "*" || c_i == "!" || c_i == "-" || c_i == "/" ||
                     c_i == "=" || c_i == ">" || c_i == "<") begin
          mode_d = M_OP2; pend_d = c_i; beg_d = pos_q;
        end else if (c_i == " ") begin
          pos_d = pos_q + 1'b1;
        end else if (c_i == "\t") begin
          failed = 1'b1; fe = ERR_TAB; fp = pos_q;
        end else if (is_let(c_i)) begin
          mode_d = M_WORD; beg_d = pos_q; wc_we = 1'b1; wc_idx = '0; wlen_d = 5'd1;
        end else if (is_dig(c_i)) begin
          mode_d = M_NUM; beg_d = pos_q; flg_d = '0;
        end else if (c_i == ".") begin
          mode_d = M_DOT; beg_d = pos_q; flg_d = '0;
        end else begin
          failed = 1'b1; fe = ERR_BAD_CHAR; fp = pos_q;
        end
      end

      if (failed) begin
        pos_d = pos_q;
        if (rescan) begin
          b_v = 1'b1; b_t = mk_err(fe, fp);
        end else begin
          a_v = 1'b1; a_t = mk_err(fe, fp);
        end
        if (c_i == 8'd0) begin
          pos_d = '0; mode_d = M_IDLE; beg_d = '0; pend_d = '0;
          wlen_d = '0; flg_d = '0; skip_d = 1'b0;
        end else begin
          skip_d = 1'b1; mode_d = M_IDLE;
        end
      end
    end
  end

  assign push0_o = acc_i && (a_v || b_v);
  assign push1_o = acc_i && a_v && b_v;
  assign res0_o  = a_v ? a_t : b_t;
  assign res1_o  = b_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pos_q  <= '0;
      beg_q  <= '0;
      pend_q <= '0;
      wlen_q <= '0;
      flg_q  <= '0;
      skip_q <= 1'b0;
    end else if (acc_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      beg_q  <= beg_d;
      pend_q <= pend_d;
      wlen_q <= wlen_d;
      flg_q  <= flg_d;
      skip_q <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && wc_we) wch_q[wc_idx] <= c_i;
  end

endmodule

### rtl/ets_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_fifo
// Result queue: two writes, one read per cycle, four entries.
// ----------------------------------------------------------------------------
module ets_fifo import ets_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push0_i,
  input  logic push1_i,
  input  tok_t din0_i,
  input  tok_t din1_i,
  output logic room2_o,
  output logic valid_o,
  input  logic pop_i,
  output tok_t dout_o
);

  tok_t       mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic [1:0] wp1;

  assign wp1      = wp_q + 2'd1;
  assign room2_o  = cnt_q <= 3'd2;
  assign valid_o  = cnt_q != 3'd0;
  assign dout_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push0_i) mem_q[wp_q] <= din0_i;
    if (push1_i) mem_q[wp1]  <= din1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + {1'b0, push0_i} + {1'b0, push1_i};
      rp_q  <= rp_q + {1'b0, pop_i};
      cnt_q <= cnt_q + {2'b0, push0_i} + {2'b0, push1_i} - {2'b0, pop_i};
    end
  end

endmodule

### rtl/expression_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_token_scanner
// Character stream to expression tokens with line-level error reporting.
// ----------------------------------------------------------------------------
//  port    | dir | transfer
//  char_i  | in  | one source byte, 0 ends the line
//  tok_o   | out | one token or error result
//
// One byte per cycle; each byte resolves in the cycle it is taken and queues
// up to two results in a four-entry queue drained one per cycle while tok_o is ready.
// Input stalls only when the queue has fewer than two free entries.
// Reset clears the scan state and empties the queue.
module expression_token_scanner import ets_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  ets_char_if.sink char_i,
  ets_tok_if.source tok_o
);

  logic acc, push0, push1, room2, fvalid;
  tok_t res0, res1, head;

  assign char_i.ready = room2;
  assign acc          = char_i.valid && room2;

  ets_scan u_scan (
    .clk_i, .rst_ni, .acc_i(acc), .c_i(char_i.char_byte),
    .push0_o(push0), .push1_o(push1), .res0_o(res0), .res1_o(res1)
  );

  ets_fifo u_fifo (
    .clk_i, .rst_ni, .push0_i(push0), .push1_i(push1), .din0_i(res0), .din1_i(res1),
    .room2_o(room2), .valid_o(fvalid), .pop_i(fvalid && tok_o.ready), .dout_o(head)
  );

  assign tok_o.valid          = fvalid;
  assign tok_o.token_kind     = head.kind;
  assign tok_o.token_start    = head.start;
  assign tok_o.token_length   = head.len;
  assign tok_o.error_code     = head.err;
  assign tok_o.error_position = head.epos;
  assign tok_o.last_of_line   = head.last;

endmodule

### rtl/ets_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_chk
// Port-level checks on the token channel.
// ----------------------------------------------------------------------------
module ets_chk import ets_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [5:0]  kind_i,
  input logic [12:0] len_i,
  input logic [3:0]  err_i,
  input logic        last_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(kind_i) && $stable(err_i))
    else $error("stalled result changed");

  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && err_i != ERR_NONE |-> last_i && kind_i == KIND_LPAREN && len_i == '0)
    else $error("malformed error result");

  a_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && err_i == ERR_NONE && kind_i == KIND_EOL |-> last_i && len_i == '0)
    else $error("malformed end of line");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && last_i && err_i == ERR_NONE |-> kind_i == KIND_EOL)
    else $error("last set on ordinary token");

endmodule

bind expression_token_scanner ets_chk u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(tok_o.valid), .ready_i(tok_o.ready),
  .kind_i(tok_o.token_kind), .len_i(tok_o.token_length), .err_i(tok_o.error_code),
  .last_i(tok_o.last_of_line)
);
